@@ hw/rtl/frame_timing_monitor_adaptive_quality_assert.svh @@
// ----------------------------------------------------------------------------
// frame timing monitor assertion macros
// shared property forms for the port checker
// ----------------------------------------------------------------------------
`ifndef FRAME_TIMING_MONITOR_ADAPTIVE_QUALITY_ASSERT_SVH
`define FRAME_TIMING_MONITOR_ADAPTIVE_QUALITY_ASSERT_SVH

// same-cycle implication
`define FTMAQ_AST_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define FTMAQ_AST_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hw/rtl/ftmaq_pkg.sv @@
// ----------------------------------------------------------------------------
// ftmaq_pkg
// types, constants and helpers of the frame timing monitor
// ----------------------------------------------------------------------------
package ftmaq_pkg;

    localparam int TIME_BITS   = 24;
    localparam int MEAN_BITS   = TIME_BITS - 1;
    localparam int NUM_CH      = 5;
    localparam int IDX_W       = $clog2(NUM_CH);
    localparam int WEIGHT_W    = 16;
    localparam int Q15_W       = 16;
    localparam int PRIM_W      = 31;
    localparam int FPS_W       = 26;
    localparam int SHARE_STEPS = 15;
    localparam int STEP_W      = $clog2(FPS_W + 1);
    localparam int PROD_W      = TIME_BITS + WEIGHT_W + 1;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = MEAN_BITS;

    localparam logic [Q15_W-1:0]  ONE_Q15 = Q15_W'(32768);
    localparam logic [FPS_W-1:0]  FPS_NUM = FPS_W'(65536000);

    // channel order of the averages
    localparam logic [IDX_W-1:0] CH_FRAME    = IDX_W'(0);
    localparam logic [IDX_W-1:0] CH_ANALYSIS = IDX_W'(1);
    localparam logic [IDX_W-1:0] CH_GEOMETRY = IDX_W'(2);
    localparam logic [IDX_W-1:0] CH_RENDER   = IDX_W'(3);
    localparam logic [IDX_W-1:0] CH_RECORD   = IDX_W'(4);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_WEIGHT,
        CFG_SLOW,
        CFG_FAST,
        CFG_FLOOR,
        CFG_STEP_DOWN,
        CFG_STEP_UP,
        CFG_ACTIVE
    } t_cfg_idx;

    typedef logic [NUM_CH-1:0][MEAN_BITS-1:0] t_mean_vec;

    typedef struct packed {
        logic signed [TIME_BITS-1:0] frame_time;
        logic signed [TIME_BITS-1:0] analysis_time;
        logic signed [TIME_BITS-1:0] geometry_time;
        logic signed [TIME_BITS-1:0] render_time;
        logic signed [TIME_BITS-1:0] record_time;
        logic [PRIM_W-1:0]           primitive_total;
        logic                        adaptive_enable;
        logic [Q15_W-1:0]            requested_quality;
    } t_in_item;

    typedef struct packed {
        logic [MEAN_BITS-1:0] last_frame;
        logic [MEAN_BITS-1:0] avg_frame;
        logic [MEAN_BITS-1:0] avg_analysis;
        logic [MEAN_BITS-1:0] avg_geometry;
        logic [MEAN_BITS-1:0] avg_render;
        logic [MEAN_BITS-1:0] avg_record;
        logic [TIME_BITS-1:0] avg_core;
        logic [FPS_W-1:0]     frames_per_second;
        logic [Q15_W-1:0]     render_share;
        logic [Q15_W-1:0]     quality_scale;
        logic                 adaptive_active;
        logic [PRIM_W-1:0]    primitives;
    } t_out_item;

    typedef struct packed {
        logic             mul;
        logic             add;
        logic             primed;
        logic [IDX_W-1:0] idx;
    } t_ema_ctl;

    typedef struct packed {
        logic              start;
        logic [STEP_W-1:0] steps;
    } t_div_cmd;

    function automatic logic [MEAN_BITS-1:0] clamp_time(input logic [TIME_BITS-1:0] raw);
        logic [MEAN_BITS-1:0] v;
        v = raw[TIME_BITS-1] ? '0 : raw[MEAN_BITS-1:0];
        return v;
    endfunction

endpackage

@@ hw/rtl/frame_timing_monitor_adaptive_quality.sv @@
// ----------------------------------------------------------------------------
// frame_timing_monitor_adaptive_quality
// smooths per-frame phase times, derives frame rate and render share, and
// steers a quality scale
// ----------------------------------------------------------------------------
//  channel  | direction | handshake              | payload
//  in       | input     | i_in_valid / o_in_stall  | t_in_item
//  out      | output    | o_out_valid / i_out_stall | t_out_item
//  cfg      | input     | i_cfg_valid / o_cfg_ready | i_cfg_index, i_cfg_data
//
// a frame report passes from acceptance to result through the averages
// (one shared 25x17 multiplier, multiply then accumulate per time), the
// frame rate and the render share on the serial divider, and the quality
// scale; zero average frame time skips both divisions, render not below frame one
// synchronous active-low reset restores the register defaults, no clearing pass
// input stalls until idle again; a stalled result holds only a finished report
// ----------------------------------------------------------------------------
module frame_timing_monitor_adaptive_quality import ftmaq_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  t_in_item              i_in_data,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output t_out_item             o_out_data,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_MUL,
        S_ADD,
        S_FPS_GO,
        S_FPS_WAIT,
        S_SHR_GO,
        S_SHR_WAIT,
        S_QUAL,
        S_DONE
    } t_state;

    t_state                          r_state;
    logic [IDX_W-1:0]                r_idx;
    logic                            r_primed;
    logic [NUM_CH-1:0][MEAN_BITS-1:0] r_samp;
    logic [PRIM_W-1:0]               r_prims;
    logic                            r_adapt;
    logic [Q15_W-1:0]                r_req;
    logic [Q15_W-1:0]                r_scale;
    logic [FPS_W-1:0]                r_fps;
    logic [Q15_W-1:0]                r_share;
    logic                            r_out_valid;
    t_out_item                       r_out;

    logic [WEIGHT_W-1:0]  r_cfg_weight;
    logic [MEAN_BITS-1:0] r_cfg_slow;
    logic [MEAN_BITS-1:0] r_cfg_fast;
    logic [Q15_W-1:0]     r_cfg_floor;
    logic [Q15_W-1:0]     r_cfg_step_down;
    logic [Q15_W-1:0]     r_cfg_step_up;
    logic [Q15_W-1:0]     r_cfg_active;

    t_ema_ctl             v_ema_ctl;
    t_div_cmd             v_div_cmd;
    t_mean_vec            v_means;
    logic [MEAN_BITS-1:0] v_div_rem0;
    logic [FPS_W-1:0]     v_div_num;
    logic                 v_div_done;
    logic [FPS_W-1:0]     v_div_quot;
    logic [MEAN_BITS-1:0] v_frame;
    logic [MEAN_BITS-1:0] v_render;
    logic [Q15_W-1:0]     v_floor;
    logic signed [Q15_W+1:0] v_s;
    logic                 v_in_acc;
    logic                 v_out_free;

    assign v_frame    = v_means[CH_FRAME];
    assign v_render   = v_means[CH_RENDER];
    assign v_in_acc   = i_in_valid && !o_in_stall;
    assign v_out_free = !r_out_valid || !i_out_stall;

    // control to the shared units
    always_comb begin
        v_ema_ctl.mul    = (r_state == S_MUL);
        v_ema_ctl.add    = (r_state == S_ADD);
        v_ema_ctl.primed = r_primed;
        v_ema_ctl.idx    = r_idx;
        v_div_cmd.start  = 1'b0;
        v_div_cmd.steps  = STEP_W'(FPS_W);
        v_div_rem0       = '0;
        v_div_num        = FPS_NUM;
        if (r_state == S_FPS_GO) begin
            v_div_cmd.start = (v_frame != '0);
        end
        if (r_state == S_SHR_GO) begin
            v_div_cmd.start = 1'b1;
            v_div_cmd.steps = STEP_W'(SHARE_STEPS);
            v_div_rem0      = v_render;
            v_div_num       = '0;
        end
    end

    ftmaq_ema u_ema (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (v_ema_ctl),
        .i_sample (r_samp[r_idx]),
        .i_weight (r_cfg_weight),
        .o_means  (v_means)
    );

    ftmaq_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (v_div_cmd),
        .i_rem0     (v_div_rem0),
        .i_dividend (v_div_num),
        .i_divisor  (v_frame),
        .o_done     (v_div_done),
        .o_quot     (v_div_quot)
    );

    // quality scale update
    always_comb begin
        v_floor = (r_cfg_floor > ONE_Q15) ? ONE_Q15 : r_cfg_floor;
        v_s     = $signed({2'b00, r_scale});
        if (r_adapt) begin
            if (v_frame > r_cfg_slow) begin
                v_s = $signed({2'b00, r_scale}) - $signed({2'b00, r_cfg_step_down});
                if (v_s < $signed({2'b00, v_floor})) begin
                    v_s = $signed({2'b00, v_floor});
                end
            end else if (v_frame < r_cfg_fast) begin
                v_s = $signed({2'b00, r_scale}) + $signed({2'b00, r_cfg_step_up});
                if (v_s > $signed({2'b00, ONE_Q15})) begin
                    v_s = $signed({2'b00, ONE_Q15});
                end
            end
        end else begin
            v_s = $signed({2'b00, r_req});
            if (v_s < $signed({2'b00, v_floor})) begin
                v_s = $signed({2'b00, v_floor});
            end
            if (v_s > $signed({2'b00, ONE_Q15})) begin
                v_s = $signed({2'b00, ONE_Q15});
            end
        end
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_weight    <= WEIGHT_W'(6554);
            r_cfg_slow      <= MEAN_BITS'(5344);
            r_cfg_fast      <= MEAN_BITS'(3078);
            r_cfg_floor     <= Q15_W'(14746);
            r_cfg_step_down <= Q15_W'(1147);
            r_cfg_step_up   <= Q15_W'(655);
            r_cfg_active    <= Q15_W'(32604);
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_WEIGHT:    r_cfg_weight    <= i_cfg_data[WEIGHT_W-1:0];
                CFG_SLOW:      r_cfg_slow      <= i_cfg_data[MEAN_BITS-1:0];
                CFG_FAST:      r_cfg_fast      <= i_cfg_data[MEAN_BITS-1:0];
                CFG_FLOOR:     r_cfg_floor     <= i_cfg_data[Q15_W-1:0];
                CFG_STEP_DOWN: r_cfg_step_down <= i_cfg_data[Q15_W-1:0];
                CFG_STEP_UP:   r_cfg_step_up   <= i_cfg_data[Q15_W-1:0];
                CFG_ACTIVE:    r_cfg_active    <= i_cfg_data[Q15_W-1:0];
                default: ;
            endcase
        end
    end

    // transaction payload capture
    always_ff @(posedge i_clk) begin
        if (v_in_acc) begin
            r_samp[CH_FRAME]    <= clamp_time(i_in_data.frame_time);
            r_samp[CH_ANALYSIS] <= clamp_time(i_in_data.analysis_time);
            r_samp[CH_GEOMETRY] <= clamp_time(i_in_data.geometry_time);
            r_samp[CH_RENDER]   <= clamp_time(i_in_data.render_time);
            r_samp[CH_RECORD]   <= clamp_time(i_in_data.record_time);
            r_prims             <= i_in_data.primitive_total;
            r_adapt             <= i_in_data.adaptive_enable;
            r_req               <= i_in_data.requested_quality;
        end
    end

    // sequencer and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_idx       <= '0;
            r_primed    <= 1'b0;
            r_scale     <= ONE_Q15;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && !i_out_stall && (r_state != S_DONE)) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_idx   <= '0;
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    r_state <= S_ADD;
                end
                S_ADD: begin
                    if (r_idx == CH_RECORD) begin
                        r_primed <= 1'b1;
                        r_state  <= S_FPS_GO;
                    end else begin
                        r_idx   <= r_idx + IDX_W'(1);
                        r_state <= S_MUL;
                    end
                end
                S_FPS_GO: begin
                    if (v_frame == '0) begin
                        r_fps   <= '0;
                        r_share <= '0;
                        r_state <= S_QUAL;
                    end else begin
                        r_state <= S_FPS_WAIT;
                    end
                end
                S_FPS_WAIT: begin
                    if (v_div_done) begin
                        r_fps <= v_div_quot;
                        if (v_render >= v_frame) begin
                            r_share <= ONE_Q15;
                            r_state <= S_QUAL;
                        end else begin
                            r_state <= S_SHR_GO;
                        end
                    end
                end
                S_SHR_GO: begin
                    r_state <= S_SHR_WAIT;
                end
                S_SHR_WAIT: begin
                    if (v_div_done) begin
                        r_share <= v_div_quot[Q15_W-1:0];
                        r_state <= S_QUAL;
                    end
                end
                S_QUAL: begin
                    r_scale <= v_s[Q15_W-1:0];
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    if (v_out_free) begin
                        r_out.last_frame        <= r_samp[CH_FRAME];
                        r_out.avg_frame         <= v_means[CH_FRAME];
                        r_out.avg_analysis      <= v_means[CH_ANALYSIS];
                        r_out.avg_geometry      <= v_means[CH_GEOMETRY];
                        r_out.avg_render        <= v_means[CH_RENDER];
                        r_out.avg_record        <= v_means[CH_RECORD];
                        r_out.avg_core          <= TIME_BITS'(v_means[CH_ANALYSIS])
                                                 + TIME_BITS'(v_means[CH_GEOMETRY]);
                        r_out.frames_per_second <= r_fps;
                        r_out.render_share      <= r_share;
                        r_out.quality_scale     <= r_scale;
                        r_out.adaptive_active   <= r_adapt && (r_scale < r_cfg_active);
                        r_out.primitives        <= r_prims;
                        r_out_valid             <= 1'b1;
                        r_state                 <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;
    assign o_cfg_ready = 1'b1;

endmodule

@@ hw/rtl/ftmaq_ema.sv @@
// ----------------------------------------------------------------------------
// ftmaq_ema
// shared multiply-accumulate unit holding the five running averages
// ----------------------------------------------------------------------------
module ftmaq_ema import ftmaq_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_ema_ctl             i_ctl,
    input  logic [MEAN_BITS-1:0] i_sample,
    input  logic [WEIGHT_W-1:0]  i_weight,
    output t_mean_vec            o_means
);

    t_mean_vec                 r_mean;
    logic signed [PROD_W-1:0]  r_prod;
    logic signed [TIME_BITS:0] v_diff;
    logic signed [PROD_W-1:0]  v_round;
    logic signed [PROD_W-1:0]  v_delta;
    logic [PROD_W-1:0]         v_sum;

    always_comb begin
        v_diff  = $signed({2'b00, i_sample}) - $signed({2'b00, r_mean[i_ctl.idx]});
        v_round = r_prod + $signed(PROD_W'(32768));
        v_delta = v_round >>> WEIGHT_W;
        v_sum   = PROD_W'(v_delta) + PROD_W'(r_mean[i_ctl.idx]);
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.mul) begin
            r_prod <= PROD_W'(v_diff * $signed({1'b0, i_weight}));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mean <= '0;
        end else if (i_ctl.add) begin
            if (i_ctl.primed) begin
                r_mean[i_ctl.idx] <= v_sum[MEAN_BITS-1:0];
            end else begin
                r_mean[i_ctl.idx] <= i_sample;
            end
        end
    end

    assign o_means = r_mean;

endmodule

@@ hw/rtl/ftmaq_div.sv @@
// ----------------------------------------------------------------------------
// ftmaq_div
// restoring serial divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module ftmaq_div import ftmaq_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_div_cmd             i_cmd,
    input  logic [MEAN_BITS-1:0] i_rem0,
    input  logic [FPS_W-1:0]     i_dividend,
    input  logic [MEAN_BITS-1:0] i_divisor,
    output logic                 o_done,
    output logic [FPS_W-1:0]     o_quot
);

    logic                 r_busy;
    logic                 r_done;
    logic [STEP_W-1:0]    r_cnt;
    logic [MEAN_BITS-1:0] r_rem;
    logic [FPS_W-1:0]     r_num;
    logic [FPS_W-1:0]     r_quot;
    logic [MEAN_BITS:0]   v_trial;
    logic [MEAN_BITS:0]   v_diff;
    logic                 v_ge;

    always_comb begin
        v_trial = {r_rem, r_num[FPS_W-1]};
        v_ge    = v_trial >= {1'b0, i_divisor};
        v_diff  = v_trial - {1'b0, i_divisor};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_cmd.start) begin
                r_busy <= 1'b1;
                r_cnt  <= i_cmd.steps;
            end else if (r_busy) begin
                r_cnt <= r_cnt - STEP_W'(1);
                if (r_cnt == STEP_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_rem  <= i_rem0;
            r_num  <= i_dividend;
            r_quot <= '0;
        end else if (r_busy) begin
            r_num  <= {r_num[FPS_W-2:0], 1'b0};
            r_quot <= {r_quot[FPS_W-2:0], v_ge};
            r_rem  <= v_ge ? v_diff[MEAN_BITS-1:0] : v_trial[MEAN_BITS-1:0];
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

endmodule

@@ hw/rtl/ftmaq_checker.sv @@
// ----------------------------------------------------------------------------
// ftmaq_checker
// port-level checks of the frame timing monitor, bound to the top level
// ----------------------------------------------------------------------------
`include "frame_timing_monitor_adaptive_quality_assert.svh"

module ftmaq_checker import ftmaq_pkg::*; (
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_in_valid,
    input logic      o_in_stall,
    input logic      o_out_valid,
    input logic      i_out_stall,
    input t_out_item o_out_data
);

    // a transaction in is followed by a busy period
    `FTMAQ_AST_NEXT(a_busy_after_accept, i_clk, i_rst_n, i_in_valid && !o_in_stall, o_in_stall, "input taken back to back")

    `FTMAQ_AST_NOW(a_core_sum, i_clk, i_rst_n, o_out_valid, o_out_data.avg_core == o_out_data.avg_analysis + o_out_data.avg_geometry, "core sum mismatch")

    `FTMAQ_AST_NOW(a_fps_zero, i_clk, i_rst_n, o_out_valid, (o_out_data.avg_frame == '0) == (o_out_data.frames_per_second == '0), "frame rate zero mismatch")

    `FTMAQ_AST_NOW(a_q15_range, i_clk, i_rst_n, o_out_valid, (o_out_data.quality_scale <= ONE_Q15) && (o_out_data.render_share <= ONE_Q15), "q15 output above one")

    // a held result stays unchanged
    `FTMAQ_AST_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid && $stable(o_out_data), "stalled result changed")

endmodule

bind frame_timing_monitor_adaptive_quality ftmaq_checker u_ftmaq_checker (.*);

@@ verif/tb_frame_timing_monitor_adaptive_quality.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_frame_timing_monitor_adaptive_quality
// sends frame reports through the monitor and checks every result against a
// cycle-free prediction of the averages, frame rate, render share and quality
// scale, across directed edge cases, register extremes, adaptive walks across
// the thresholds and random traffic with random gaps and stalls
// ----------------------------------------------------------------------------
module tb_frame_timing_monitor_adaptive_quality;
    import ftmaq_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 1000000;
    localparam logic [MEAN_BITS-1:0] TIME_MAX = {MEAN_BITS{1'b1}};

    typedef enum {ADAPT_OFF, ADAPT_ON, ADAPT_MIXED} t_adapt_mode;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_in_valid = 1'b0;
    logic                  o_in_stall;
    t_in_item              i_in_data = '0;
    logic                  o_out_valid;
    logic                  i_out_stall = 1'b0;
    t_out_item             o_out_data;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    // predicted register and state copy
    logic [WEIGHT_W-1:0]  cfg_weight = 16'd6554;
    logic [MEAN_BITS-1:0] cfg_slow = 23'd5344;
    logic [MEAN_BITS-1:0] cfg_fast = 23'd3078;
    logic [Q15_W-1:0]     cfg_floor = 16'd14746;
    logic [Q15_W-1:0]     cfg_down = 16'd1147;
    logic [Q15_W-1:0]     cfg_up = 16'd655;
    logic [Q15_W-1:0]     cfg_active = 16'd32604;
    logic                 seen_first = 1'b0;
    logic [MEAN_BITS-1:0] smooth_t [NUM_CH] = '{default: '0};
    logic [Q15_W-1:0]     quality_q15 = ONE_Q15;

    t_out_item   expected_reports [$];
    int unsigned mismatch_count = 0;
    int unsigned reports_sent = 0;
    int unsigned reports_checked = 0;
    int unsigned settings_applied = 0;
    int unsigned adaptive_reports = 0;
    int unsigned shares_clamped = 0;
    int unsigned zero_frame_avgs = 0;
    int unsigned cycle_count = 0;
    int unsigned hold_cycles = 0;
    bit          send_gaps_on = 1'b0;
    bit          stalls_on = 1'b0;

    frame_timing_monitor_adaptive_quality u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always #4 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    function automatic logic [MEAN_BITS-1:0] non_negative(input logic signed [TIME_BITS-1:0] t);
        if (t < 0)
            return '0;
        return t[MEAN_BITS-1:0];
    endfunction

    function automatic logic [MEAN_BITS-1:0] ema_next(input logic [MEAN_BITS-1:0] mean_v,
                                                      input logic [MEAN_BITS-1:0] x);
        longint unsigned acc;
        if (!seen_first)
            return x;
        acc = longint'(mean_v) * (65536 - longint'(cfg_weight))
            + longint'(x) * longint'(cfg_weight) + 32768;
        return MEAN_BITS'(acc >> 16);
    endfunction

    task automatic predict_report(input t_in_item it);
        t_out_item            rep;
        logic [MEAN_BITS-1:0] sample [NUM_CH];
        logic [Q15_W-1:0]     floor_eff;
        longint               scale_s;
        longint unsigned      ratio;
        sample[CH_FRAME]    = non_negative(it.frame_time);
        sample[CH_ANALYSIS] = non_negative(it.analysis_time);
        sample[CH_GEOMETRY] = non_negative(it.geometry_time);
        sample[CH_RENDER]   = non_negative(it.render_time);
        sample[CH_RECORD]   = non_negative(it.record_time);
        for (int ch = 0; ch < NUM_CH; ch++)
            smooth_t[ch] = ema_next(smooth_t[ch], sample[ch]);
        seen_first = 1'b1;

        rep = '0;
        rep.last_frame   = sample[CH_FRAME];
        rep.avg_frame    = smooth_t[CH_FRAME];
        rep.avg_analysis = smooth_t[CH_ANALYSIS];
        rep.avg_geometry = smooth_t[CH_GEOMETRY];
        rep.avg_render   = smooth_t[CH_RENDER];
        rep.avg_record   = smooth_t[CH_RECORD];
        rep.avg_core     = {1'b0, smooth_t[CH_ANALYSIS]} + {1'b0, smooth_t[CH_GEOMETRY]};
        if (smooth_t[CH_FRAME] != '0) begin
            rep.frames_per_second = FPS_W'(longint'(FPS_NUM) / longint'(smooth_t[CH_FRAME]));
            ratio = (longint'(smooth_t[CH_RENDER]) << 15) / longint'(smooth_t[CH_FRAME]);
            if (ratio >= longint'(ONE_Q15)) begin
                ratio = longint'(ONE_Q15);
                shares_clamped++;
            end
            rep.render_share = Q15_W'(ratio);
        end else begin
            zero_frame_avgs++;
        end

        floor_eff = (cfg_floor > ONE_Q15) ? ONE_Q15 : cfg_floor;
        scale_s = longint'(quality_q15);
        if (it.adaptive_enable) begin
            adaptive_reports++;
            if (smooth_t[CH_FRAME] > cfg_slow) begin
                scale_s -= longint'(cfg_down);
                if (scale_s < longint'(floor_eff))
                    scale_s = longint'(floor_eff);
            end else if (smooth_t[CH_FRAME] < cfg_fast) begin
                scale_s += longint'(cfg_up);
                if (scale_s > longint'(ONE_Q15))
                    scale_s = longint'(ONE_Q15);
            end
        end else begin
            scale_s = longint'(it.requested_quality);
            if (scale_s < longint'(floor_eff))
                scale_s = longint'(floor_eff);
            if (scale_s > longint'(ONE_Q15))
                scale_s = longint'(ONE_Q15);
        end
        quality_q15 = Q15_W'(scale_s);
        rep.quality_scale   = quality_q15;
        rep.adaptive_active = it.adaptive_enable && (quality_q15 < cfg_active);
        rep.primitives      = it.primitive_total;
        expected_reports.push_back(rep);
    endtask

    task automatic check_field(input string fname, input logic [63:0] want,
                               input logic [63:0] got);
        if (want !== got) begin
            mismatch_count++;
            if (mismatch_count <= 10)
                $display("result %0d %s: expected %0d, got %0d",
                         reports_checked, fname, want, got);
        end
    endtask

    task automatic check_report(input t_out_item got);
        t_out_item want;
        if (expected_reports.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
                $display("result %0d arrived with no frame report pending", reports_checked);
        end else begin
            want = expected_reports.pop_front();
            check_field("last_frame", want.last_frame, got.last_frame);
            check_field("avg_frame", want.avg_frame, got.avg_frame);
            check_field("avg_analysis", want.avg_analysis, got.avg_analysis);
            check_field("avg_geometry", want.avg_geometry, got.avg_geometry);
            check_field("avg_render", want.avg_render, got.avg_render);
            check_field("avg_record", want.avg_record, got.avg_record);
            check_field("avg_core", want.avg_core, got.avg_core);
            check_field("frames_per_second", want.frames_per_second, got.frames_per_second);
            check_field("render_share", want.render_share, got.render_share);
            check_field("quality_scale", want.quality_scale, got.quality_scale);
            check_field("adaptive_active", want.adaptive_active, got.adaptive_active);
            check_field("primitives", want.primitives, got.primitives);
        end
        reports_checked++;
    endtask

    // result side: with stalls on, stall the result port for a randomly drawn hold after each result taken
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) begin
                check_report(o_out_data);
                hold_cycles = stalls_on ? $urandom_range(0, 13) : 0;
            end else if (o_out_valid && hold_cycles != 0) begin
                hold_cycles--;
            end
            i_out_stall <= (hold_cycles != 0);
        end
    end

    task automatic send_report(input t_in_item it);
        int unsigned gap;
        gap = send_gaps_on ? $urandom_range(0, 13) : 0;
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= it;
        @(posedge i_clk);
        while (o_in_stall)
            @(posedge i_clk);
        predict_report(it);
        reports_sent++;
    endtask

    task automatic wait_for_reports(input int unsigned settle);
        i_in_valid <= 1'b0;
        while (expected_reports.size() != 0)
            @(posedge i_clk);
        repeat (settle) @(posedge i_clk);
    endtask

    task automatic store_setting(input t_cfg_idx idx, input logic [CFG_DATA_W-1:0] v);
        case (idx)
            CFG_WEIGHT:    cfg_weight = v[WEIGHT_W-1:0];
            CFG_SLOW:      cfg_slow = v;
            CFG_FAST:      cfg_fast = v;
            CFG_FLOOR:     cfg_floor = v[Q15_W-1:0];
            CFG_STEP_DOWN: cfg_down = v[Q15_W-1:0];
            CFG_STEP_UP:   cfg_up = v[Q15_W-1:0];
            CFG_ACTIVE:    cfg_active = v[Q15_W-1:0];
            default: ;
        endcase
    endtask

    // waits until the block is drained and idle before writing the registers
    task automatic apply_settings(input int unsigned weight, slow, fast, floor_q,
                                  down, up, active);
        logic [CFG_DATA_W-1:0] vals [7];
        t_cfg_idx              order [7];
        vals  = '{CFG_DATA_W'(weight), CFG_DATA_W'(slow), CFG_DATA_W'(fast),
                  CFG_DATA_W'(floor_q), CFG_DATA_W'(down), CFG_DATA_W'(up),
                  CFG_DATA_W'(active)};
        order = '{CFG_WEIGHT, CFG_SLOW, CFG_FAST, CFG_FLOOR, CFG_STEP_DOWN, CFG_STEP_UP,
                  CFG_ACTIVE};
        wait_for_reports(8);
        for (int k = 0; k < 7; k++) begin
            i_cfg_valid <= 1'b1;
            i_cfg_index <= order[k];
            i_cfg_data  <= vals[k];
            @(posedge i_clk);
            while (!o_cfg_ready)
                @(posedge i_clk);
            store_setting(order[k], vals[k]);
        end
        i_cfg_valid <= 1'b0;
        settings_applied++;
    endtask

    function automatic t_in_item report_of(input int f, a, g, r, c, input int unsigned prims,
                                           input bit adp, input int unsigned req);
        t_in_item it;
        it.frame_time        = TIME_BITS'(f);
        it.analysis_time     = TIME_BITS'(a);
        it.geometry_time     = TIME_BITS'(g);
        it.render_time       = TIME_BITS'(r);
        it.record_time       = TIME_BITS'(c);
        it.primitive_total   = PRIM_W'(prims);
        it.adaptive_enable   = adp;
        it.requested_quality = Q15_W'(req);
        return it;
    endfunction

    function automatic logic [TIME_BITS-1:0] pick_time(input int unsigned centre, input bit noisy);
        int unsigned v;
        case ($urandom_range(0, noisy ? 9 : 59))
            0: return TIME_BITS'($urandom);
            1: return {1'b1, MEAN_BITS'($urandom)};
            2: return $urandom_range(0, 1) ? {1'b0, TIME_MAX} : {1'b1, {MEAN_BITS{1'b0}}};
            default: begin
                v = $urandom_range(0, 2 * centre + 1);
                if (v > TIME_MAX)
                    v = TIME_MAX;
                return TIME_BITS'(v);
            end
        endcase
    endfunction

    function automatic t_in_item random_report(input int unsigned centre,
                                               input t_adapt_mode mode, input bit noisy);
        t_in_item it;
        it.frame_time    = pick_time(centre, noisy);
        it.analysis_time = pick_time(centre / 4, noisy);
        it.geometry_time = pick_time(centre / 3, noisy);
        it.render_time   = pick_time(($urandom_range(0, 3) == 0) ? centre : centre / 2, noisy);
        it.record_time   = pick_time(centre / 8, noisy);
        it.primitive_total = PRIM_W'($urandom);
        case (mode)
            ADAPT_OFF: it.adaptive_enable = 1'b0;
            ADAPT_ON:  it.adaptive_enable = ($urandom_range(0, 15) != 0);
            default:   it.adaptive_enable = 1'($urandom);
        endcase
        it.requested_quality = $urandom_range(0, 1) ? Q15_W'($urandom)
                                                    : Q15_W'($urandom_range(0, 32768));
        return it;
    endfunction

    task automatic set_idling(input bit sender, input bit receiver);
        send_gaps_on = sender;
        stalls_on    = receiver;
    endtask

    task automatic test_directed_edges();
        set_idling(1'b1, 1'b1);
        // first frame loads the averages, zero frame time gives no rate
        send_report(report_of(0, 0, 0, 0, 0, 0, 1'b0, 0));
        send_report(report_of(0, 5, 5, 5, 5, 1, 1'b1, 0));
        // render above frame time saturates the share
        send_report(report_of(4000, 1000, 1200, 9000, 800, 12345, 1'b1, 32768));
        send_report(report_of(8388607, 8388607, 8388607, 8388607, 8388607, 32'h7FFFFFFF,
                              1'b0, 65535));
        send_report(report_of(-8388608, -8388608, -8388608, -8388608, -8388608, 0,
                              1'b0, 32768));
        send_report(report_of(-1, -1, -1, -1, -1, 32'h55555555, 1'b1, 0));
        send_report(report_of(24'h555555, 24'h2AAAAA, 24'h155555, 24'h0AAAAA, 24'h055555,
                              32'h2AAAAAAA, 1'b0, 16'hAAAA));
        send_report(report_of(24'hAAAAAA, 24'hD55555, 24'hAAAAAA, 24'hD55555, 24'hAAAAAA,
                              32'h55555555, 1'b1, 16'h5555));
        // requested quality around the floor and above one
        send_report(report_of(3000, 500, 500, 1500, 400, 7, 1'b0, 14745));
        send_report(report_of(3000, 500, 500, 1500, 400, 8, 1'b0, 14746));
        send_report(report_of(3000, 500, 500, 1500, 400, 9, 1'b0, 32769));
        // slow frames walk the scale down towards the floor
        for (int k = 0; k < 6; k++)
            send_report(report_of(8388607, 2000, 2000, 4000, 1000, k, 1'b1, 0));
        for (int k = 0; k < 4; k++)
            send_report(report_of(0, 0, 0, 0, 0, k, 1'b1, 65535));
        send_report(report_of(1, 1, 0, 1, 0, 1, 1'b1, 0));
    endtask

    task automatic test_register_extremes();
        set_idling(1'b1, 1'b0);
        apply_settings(65535, 0, 0, 0, 32768, 32768, 32768);
        repeat (60) send_report(random_report(3000, ADAPT_MIXED, 1'b1));
        set_idling(1'b0, 1'b1);
        apply_settings(1, TIME_MAX, TIME_MAX, 32768, 0, 0, 0);
        repeat (60) send_report(random_report(3000, ADAPT_MIXED, 1'b1));
    endtask

    task automatic test_adaptive_walk();
        int unsigned fast_t, slow_t, centre, burst, sent;
        for (int round = 0; round < 4; round++) begin
            fast_t = $urandom_range(500, 4000);
            slow_t = fast_t + $urandom_range(0, 3000);
            set_idling(round[0], round[1]);
            apply_settings($urandom_range(16384, 65535), slow_t, fast_t,
                           $urandom_range(0, 30000), $urandom_range(1, 3000),
                           $urandom_range(1, 3000), $urandom_range(8000, 32768));
            sent = 0;
            while (sent < 125) begin
                burst = $urandom_range(3, 20);
                case ($urandom_range(0, 2))
                    0: centre = slow_t + slow_t / 2 + 50;
                    1: centre = fast_t / 2;
                    default: centre = (slow_t + fast_t) / 2;
                endcase
                repeat (burst) send_report(random_report(centre, ADAPT_ON, 1'b0));
                sent += burst;
            end
        end
    endtask

    task automatic test_random_traffic();
        int unsigned fast_t, slow_t, weight, sent, burst;
        for (int round = 0; round < 6; round++) begin
            fast_t = $urandom_range(0, 6000);
            slow_t = fast_t + $urandom_range(0, 6000);
            if ($urandom_range(0, 4) == 0)
                slow_t = $urandom_range(0, TIME_MAX);
            if ($urandom_range(0, 3) == 0)
                weight = $urandom_range(0, 1) ? 1 : 65535;
            else
                weight = $urandom_range(1, 65535);
            if (round == 0)
                set_idling(1'b0, 1'b0);
            else
                set_idling($urandom_range(0, 3) != 0, $urandom_range(0, 3) != 0);
            apply_settings(weight, slow_t, fast_t, $urandom_range(0, 32768),
                           ($urandom_range(0, 7) == 0) ? 32768 : $urandom_range(0, 3000),
                           ($urandom_range(0, 7) == 0) ? 32768 : $urandom_range(0, 3000),
                           $urandom_range(0, 32768));
            sent = 0;
            while (sent < 120) begin
                burst = $urandom_range(1, 16);
                repeat (burst)
                    send_report(random_report($urandom_range(0, 2 * slow_t + 100),
                                              ADAPT_MIXED, 1'b1));
                sent += burst;
            end
        end
    endtask

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed_edges();
        test_register_extremes();
        test_adaptive_walk();
        test_random_traffic();

        wait_for_reports(100);
        $display("frame reports sent %0d, results checked %0d, register settings %0d",
                 reports_sent, reports_checked, settings_applied);
        $display("adaptive reports %0d, saturated render shares %0d, zero frame averages %0d",
                 adaptive_reports, shares_clamped, zero_frame_avgs);
        if (mismatch_count == 0 && expected_reports.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
+incdir+hw/rtl
hw/rtl/ftmaq_pkg.sv
hw/rtl/ftmaq_ema.sv
hw/rtl/ftmaq_div.sv
hw/rtl/frame_timing_monitor_adaptive_quality.sv
hw/rtl/ftmaq_checker.sv
verif/tb_frame_timing_monitor_adaptive_quality.sv
